### hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/rmn_pkg.sv
`timescale 1ns / 1ps
package rmn_pkg;

    localparam int MAX_ACTIONS = 8;
    localparam int CNT_W       = 4;
    localparam int PROB_W      = 16;
    localparam logic [PROB_W-1:0] PROB_ONE = 16'd32768;

    // Control word that travels with each beat through the pipeline.
    typedef struct packed {
        logic             vld;
        logic             last;
        logic             uniform;
        logic [CNT_W-1:0] cnt;
    } t_ctrl;

    // Uniform probability floor(32768 / n) for n active actions.
    function automatic logic [PROB_W-1:0] uniform_prob(input logic [CNT_W-1:0] n);
        logic [PROB_W-1:0] p;
        case (n)
            4'd1:    p = 16'd32768;
            4'd2:    p = 16'd16384;
            4'd3:    p = 16'd10922;
            4'd4:    p = 16'd8192;
            4'd5:    p = 16'd6553;
            4'd6:    p = 16'd5461;
            4'd7:    p = 16'd4681;
            4'd8:    p = 16'd4096;
            default: p = 16'd0;
        endcase
        return p;
    endfunction

endpackage

### hdl/rmn_div_stage.sv
`timescale 1ns / 1ps
module rmn_div_stage import rmn_pkg::*; #(
    parameter int SUM_W = 34,
    parameter int STAGE = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  t_ctrl                                 i_ctrl,
    input  logic [SUM_W-1:0]                      i_sum,
    input  logic [MAX_ACTIONS-1:0][SUM_W-1:0]     i_rem,
    input  logic [MAX_ACTIONS-1:0][PROB_W-1:0]    i_quo,
    output t_ctrl                                 o_ctrl,
    output logic [SUM_W-1:0]                      o_sum,
    output logic [MAX_ACTIONS-1:0][SUM_W-1:0]     o_rem,
    output logic [MAX_ACTIONS-1:0][PROB_W-1:0]    o_quo
);

    localparam int STEPS = 2;

    t_ctrl                               r_ctrl;
    logic [SUM_W-1:0]                    r_sum;
    logic [MAX_ACTIONS-1:0][SUM_W-1:0]   r_rem, n_rem;
    logic [MAX_ACTIONS-1:0][PROB_W-1:0]  r_quo, n_quo;

    // Two restoring-division steps per lane; the very first step does not double.
    always_comb begin
        logic [SUM_W:0] t;
        logic [SUM_W-1:0] r;
        logic [PROB_W-1:0] q;
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            r = i_rem[a];
            q = i_quo[a];
            for (int j = 0; j < STEPS; j++) begin
                if ((STAGE * STEPS + j) == 0) begin
                    t = {1'b0, r};
                end else begin
                    t = {r, 1'b0};
                end
                if (t >= {1'b0, i_sum}) begin
                    r = SUM_W'(t - {1'b0, i_sum});
                    q = {q[PROB_W-2:0], 1'b1};
                end else begin
                    r = SUM_W'(t);
                    q = {q[PROB_W-2:0], 1'b0};
                end
            end
            n_rem[a] = r;
            n_quo[a] = q;
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.vld <= 1'b0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
            r_sum  <= i_sum;
            r_rem  <= n_rem;
            r_quo  <= n_quo;
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_sum  = r_sum;
    assign o_rem  = r_rem;
    assign o_quo  = r_quo;

endmodule

### hdl/regret_matching_normalizer.sv
// Path: an accepted input beat passes stages s1, s2 and s3, the eight-stage
// pipelined divider (two quotient bits per stage) and the output register.
// Rate: one bucket per cycle unless the output stalls; depth is not the limit.
// Reset: synchronous active-low i_rst_n clears every stage valid bit and
// sets action_count to 8; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module regret_matching_normalizer import rmn_pkg::*; #(
    parameter int REGRET_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CNT_W-1:0]       i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [REGRET_BITS-1:0] i_regret_a0,
    input  logic [REGRET_BITS-1:0] i_regret_a1,
    input  logic [REGRET_BITS-1:0] i_regret_a2,
    input  logic [REGRET_BITS-1:0] i_regret_a3,
    input  logic [REGRET_BITS-1:0] i_regret_a4,
    input  logic [REGRET_BITS-1:0] i_regret_a5,
    input  logic [REGRET_BITS-1:0] i_regret_a6,
    input  logic [REGRET_BITS-1:0] i_regret_a7,
    input  logic                   i_last_bucket,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [PROB_W-1:0]      o_prob_a0,
    output logic [PROB_W-1:0]      o_prob_a1,
    output logic [PROB_W-1:0]      o_prob_a2,
    output logic [PROB_W-1:0]      o_prob_a3,
    output logic [PROB_W-1:0]      o_prob_a4,
    output logic [PROB_W-1:0]      o_prob_a5,
    output logic [PROB_W-1:0]      o_prob_a6,
    output logic [PROB_W-1:0]      o_prob_a7,
    output logic                   o_uniform_used,
    output logic                   o_last_out
);

    localparam int SUM_W = REGRET_BITS - 1 + $clog2(MAX_ACTIONS);
    localparam int HALF  = MAX_ACTIONS / 2;
    localparam int NDIV  = PROB_W / 2;

    logic                                w_en;
    logic [MAX_ACTIONS-1:0][REGRET_BITS-1:0] w_reg;
    logic [CNT_W-1:0]                    r_action_count;
    logic [CNT_W-1:0]                    w_cnt;

    t_ctrl                               r_s1_ctrl, r_s2_ctrl, r_s3_ctrl, r_out_ctrl;
    logic [MAX_ACTIONS-1:0][SUM_W-1:0]   r_s1_pos, r_s2_pos, r_s3_pos, n_s1_pos;
    logic [1:0][SUM_W-1:0]               r_s2_half, n_s2_half;
    logic [SUM_W-1:0]                    r_s3_sum, n_s3_sum;
    logic [MAX_ACTIONS-1:0][PROB_W-1:0]  r_prob, n_prob;

    t_ctrl                               w_ctrl [NDIV+1];
    logic [SUM_W-1:0]                    w_sum  [NDIV+1];
    logic [MAX_ACTIONS-1:0][SUM_W-1:0]   w_rem  [NDIV+1];
    logic [MAX_ACTIONS-1:0][PROB_W-1:0]  w_quo  [NDIV+1];

    // Global advance: the whole pipe moves unless the output beat is stalled.
    assign w_en    = !r_out_ctrl.vld || i_ready;
    assign o_ready = w_en;

    assign w_reg = {i_regret_a7, i_regret_a6, i_regret_a5, i_regret_a4,
                    i_regret_a3, i_regret_a2, i_regret_a1, i_regret_a0};

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action_count <= CNT_W'(MAX_ACTIONS);
        end else if (i_cfg_we) begin
            r_action_count <= i_cfg_data;
        end
    end

    // Effective action count, saturated to one..MAX_ACTIONS.
    always_comb begin
        if (r_action_count == '0) begin
            w_cnt = CNT_W'(1);
        end else if (r_action_count > CNT_W'(MAX_ACTIONS)) begin
            w_cnt = CNT_W'(MAX_ACTIONS);
        end else begin
            w_cnt = r_action_count;
        end
    end

    // Clamp negatives and inactive actions to zero.
    always_comb begin
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            if (CNT_W'(a) < w_cnt && !w_reg[a][REGRET_BITS-1]) begin
                n_s1_pos[a] = SUM_W'(w_reg[a][REGRET_BITS-2:0]);
            end else begin
                n_s1_pos[a] = '0;
            end
        end
    end

    // Two half sums, then the total.
    always_comb begin
        n_s2_half = '0;
        for (int a = 0; a < HALF; a++) begin
            n_s2_half[0] = n_s2_half[0] + r_s1_pos[a];
            n_s2_half[1] = n_s2_half[1] + r_s1_pos[a + HALF];
        end
        n_s3_sum = r_s2_half[0] + r_s2_half[1];
    end

    // Front stages: clamp, half sums, total sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl.vld <= 1'b0;
            r_s2_ctrl.vld <= 1'b0;
            r_s3_ctrl.vld <= 1'b0;
        end else if (w_en) begin
            r_s1_ctrl <= '{vld: i_valid, last: i_last_bucket, uniform: 1'b0, cnt: w_cnt};
            r_s1_pos  <= n_s1_pos;
            r_s2_ctrl <= r_s1_ctrl;
            r_s2_pos  <= r_s1_pos;
            r_s2_half <= n_s2_half;
            r_s3_ctrl <= '{vld: r_s2_ctrl.vld, last: r_s2_ctrl.last,
                           uniform: (n_s3_sum == '0), cnt: r_s2_ctrl.cnt};
            r_s3_pos  <= r_s2_pos;
            r_s3_sum  <= n_s3_sum;
        end
    end

    // Pipelined divider: quotient = pos * 2^15 / sum.
    assign w_ctrl[0] = r_s3_ctrl;
    assign w_sum[0]  = r_s3_sum;
    assign w_rem[0]  = r_s3_pos;
    assign w_quo[0]  = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        rmn_div_stage #(
            .SUM_W (SUM_W),
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[g]),
            .i_sum   (w_sum[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_sum   (w_sum[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1])
        );
    end

    // Select uniform or divided probability; inactive actions give zero.
    always_comb begin
        for (int a = 0; a < MAX_ACTIONS; a++) begin
            if (CNT_W'(a) >= w_ctrl[NDIV].cnt) begin
                n_prob[a] = '0;
            end else if (w_ctrl[NDIV].uniform) begin
                n_prob[a] = uniform_prob(w_ctrl[NDIV].cnt);
            end else begin
                n_prob[a] = w_quo[NDIV][a];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ctrl.vld <= 1'b0;
        end else if (w_en) begin
            r_out_ctrl <= w_ctrl[NDIV];
            r_prob     <= n_prob;
        end
    end

    assign o_valid        = r_out_ctrl.vld;
    assign o_uniform_used = r_out_ctrl.uniform;
    assign o_last_out     = r_out_ctrl.last;
    assign o_prob_a0      = r_prob[0];
    assign o_prob_a1      = r_prob[1];
    assign o_prob_a2      = r_prob[2];
    assign o_prob_a3      = r_prob[3];
    assign o_prob_a4      = r_prob[4];
    assign o_prob_a5      = r_prob[5];
    assign o_prob_a6      = r_prob[6];
    assign o_prob_a7      = r_prob[7];

    // Action zero is always active, so a uniform result never gives it zero.
    `ASSERT_IMPLIES(a_uniform_nonzero, i_clk, i_rst_n,
        o_valid && o_uniform_used, o_prob_a0 != '0)
    // The probability of action zero never exceeds one.
    `ASSERT_IMPLIES(a_prob_bound, i_clk, i_rst_n, o_valid, o_prob_a0 <= PROB_ONE)
    // The last action is zero whenever it lies beyond the action count.
    `ASSERT_IMPLIES(a_inactive_zero, i_clk, i_rst_n,
        o_valid && (r_out_ctrl.cnt < CNT_W'(MAX_ACTIONS)), o_prob_a7 == '0)

endmodule
